### hdl/aspd_pkg.sv
package aspd_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int MAX_REPEAT = 64;

  localparam int SAMPLE_W  = 32;
  localparam int CHAN_W    = 4;
  localparam int GAIN_W    = 24;
  localparam int PERIOD_W  = 20;
  localparam int REPEAT_W  = 7;
  localparam int DUTY_W    = 20;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 24;

  // 268.8 in Q20.8, rounded
  localparam int unsigned DUTY_MIN_Q8 = 68813;
  // ceil(2^34 / 5): exact floor(x / 5) for any x below 2^32 after >> 34
  localparam logic [31:0] DIV5_RECIP = 32'd3435973837;

  localparam logic [GAIN_W-1:0]   GAIN_RST   = 24'd65536;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 20'd4096;
  localparam logic [REPEAT_W-1:0] REPEAT_RST = 7'd1;
  localparam logic [CHAN_W-1:0]   SLOT_RST   = 4'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PWM_GAIN      = 8'd0,
    REG_PERIOD_COUNT  = 8'd1,
    REG_REPEAT_COUNT  = 8'd2,
    REG_SELECTED_SLOT = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   pwm_gain;
    logic [PERIOD_W-1:0] period_count;
    logic [REPEAT_W-1:0] repeat_count;
    logic [CHAN_W-1:0]   selected_slot;
  } cfg_t;

  // one finished duty word heading for the repeater
  typedef struct packed {
    logic [DUTY_W-1:0]   duty;
    logic [REPEAT_W-1:0] copies;
    logic                eob;
  } duty_res_t;

endpackage

### hdl/aspd_in_if.sv
interface aspd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [aspd_pkg::SAMPLE_W-1:0]  sample;
  logic        [aspd_pkg::CHAN_W-1:0]    channel_index;
  logic                                  end_of_block;

  modport source (output valid, output sample, output channel_index, output end_of_block,
                  input ready);
  modport sink   (input valid, input sample, input channel_index, input end_of_block,
                  output ready);
endinterface

### hdl/aspd_out_if.sv
interface aspd_out_if;
  logic                           valid;
  logic                           ready;
  logic [aspd_pkg::DUTY_W-1:0]    duty_count;
  logic                           last_copy;
  logic                           block_done;

  modport source (output valid, output duty_count, output last_copy, output block_done,
                  input ready);
  modport sink   (input valid, input duty_count, input last_copy, input block_done,
                  output ready);
endinterface

### hdl/aspd_cfg_if.sv
interface aspd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [aspd_pkg::CFG_IDX_W-1:0]    index;
  logic [aspd_pkg::CFG_DAT_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/aspd_cfg_regs.sv
module aspd_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  aspd_cfg_if.sink        cfg_ch,
  output aspd_pkg::cfg_t  cfg
);
  import aspd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_PWM_GAIN:      cfg_nxt.pwm_gain      = cfg_ch.data[GAIN_W-1:0];
        REG_PERIOD_COUNT:  cfg_nxt.period_count  = cfg_ch.data[PERIOD_W-1:0];
        REG_REPEAT_COUNT:  cfg_nxt.repeat_count  = cfg_ch.data[REPEAT_W-1:0];
        REG_SELECTED_SLOT: cfg_nxt.selected_slot = cfg_ch.data[CHAN_W-1:0];
        default:           cfg_nxt = cfg_r;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_gain      <= GAIN_RST;
      cfg_r.period_count  <= PERIOD_RST;
      cfg_r.repeat_count  <= REPEAT_RST;
      cfg_r.selected_slot <= SLOT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### hdl/aspd_datapath.sv
module aspd_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  aspd_in_if.sink              in_ch,
  input  aspd_pkg::cfg_t       cfg,
  output logic                 res_valid,
  input  logic                 res_ready,
  output aspd_pkg::duty_res_t  res
);
  import aspd_pkg::*;

  // stall chain: a stage moves when empty or when the next one moves
  logic go1, go2, go3, go4;
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt;

  // stage 1: gain product, dmax numerator, centre
  logic signed [56:0]         prod1_r, prod1_nxt;
  logic        [30:0]         num1_r, num1_nxt;
  logic        [26:0]         ctr1_r;
  logic        [REPEAT_W-1:0] cop1_r, cop1_nxt;
  logic                       eob1_r;
  logic                       slot_hit;

  // stage 2: saturated gain, dmax
  logic signed [40:0]         gsh;
  logic signed [31:0]         g2_r, g2_nxt;
  logic        [62:0]         q5;
  logic        [27:0]         dmax2_r;
  logic        [26:0]         ctr2_r;
  logic        [REPEAT_W-1:0] cop2_r;
  logic                       eob2_r;

  // stage 3: swing product
  logic signed [28:0]         span;
  logic signed [60:0]         prod3_r, prod3_nxt;
  logic        [27:0]         dmax3_r;
  logic        [26:0]         ctr3_r;
  logic        [REPEAT_W-1:0] cop3_r;
  logic                       eob3_r;

  // stage 4: offset, clamp, round
  logic signed [29:0]         duty_s, duty_lo, duty_cl;
  logic        [29:0]         rnd;
  logic        [DUTY_W-1:0]   word4_r;
  logic        [REPEAT_W-1:0] cop4_r;
  logic                       eob4_r;

  assign go4 = !v4_r || res_ready;
  assign go3 = !v3_r || go4;
  assign go2 = !v2_r || go3;
  assign go1 = !v1_r || go2;

  assign in_ch.ready = go1;

  always_comb begin
    slot_hit = (int'(cfg.selected_slot) < SLOT_COUNT) &&
               (in_ch.channel_index == cfg.selected_slot);
    v1_nxt    = in_ch.valid && slot_hit;
    prod1_nxt = in_ch.sample * signed'({1'b0, cfg.pwm_gain});
    num1_nxt  = {11'd0, cfg.period_count} * 31'd1216 + 31'd2;
    if (cfg.repeat_count == '0) begin
      cop1_nxt = REPEAT_W'(1);
    end else if (int'(cfg.repeat_count) > MAX_REPEAT) begin
      cop1_nxt = REPEAT_W'(MAX_REPEAT);
    end else begin
      cop1_nxt = cfg.repeat_count;
    end
  end

  always_comb begin
    // floor of the product over 2^16
    gsh = prod1_r[56:16];
    if (gsh > 41'sd2147483647) begin
      g2_nxt = 32'sh7fffffff;
    end else if (gsh < -41'sd2147483648) begin
      g2_nxt = 32'sh80000000;
    end else begin
      g2_nxt = gsh[31:0];
    end
    q5 = {32'd0, num1_r} * {31'd0, DIV5_RECIP};
  end

  always_comb begin
    span      = signed'({1'b0, dmax2_r}) - signed'(29'(DUTY_MIN_Q8));
    prod3_nxt = g2_r * span;
  end

  always_comb begin
    // swing is the floor of the product over 2^32, sign extended
    duty_s  = signed'({3'd0, ctr3_r}) + signed'({prod3_r[60], prod3_r[60:32]});
    duty_lo = (duty_s < signed'(30'(DUTY_MIN_Q8))) ? signed'(30'(DUTY_MIN_Q8)) : duty_s;
    duty_cl = (duty_lo > signed'({2'd0, dmax3_r})) ? signed'({2'd0, dmax3_r}) : duty_lo;
    rnd     = unsigned'(duty_cl) + 30'd128;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (go1) v1_r <= v1_nxt;
      if (go2) v2_r <= v1_r;
      if (go3) v3_r <= v2_r;
      if (go4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      prod1_r <= prod1_nxt;
      num1_r  <= num1_nxt;
      ctr1_r  <= {cfg.period_count[PERIOD_W-1:1], 8'd0};
      cop1_r  <= cop1_nxt;
      eob1_r  <= in_ch.end_of_block;
    end
    if (go2) begin
      g2_r    <= g2_nxt;
      dmax2_r <= q5[61:34];
      ctr2_r  <= ctr1_r;
      cop2_r  <= cop1_r;
      eob2_r  <= eob1_r;
    end
    if (go3) begin
      prod3_r <= prod3_nxt;
      dmax3_r <= dmax2_r;
      ctr3_r  <= ctr2_r;
      cop3_r  <= cop2_r;
      eob3_r  <= eob2_r;
    end
    if (go4) begin
      word4_r <= rnd[27:8];
      cop4_r  <= cop3_r;
      eob4_r  <= eob3_r;
    end
  end

  assign res_valid  = v4_r;
  assign res.duty   = word4_r;
  assign res.copies = cop4_r;
  assign res.eob    = eob4_r;

endmodule

### hdl/aspd_repeater.sv
module aspd_repeater (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  output logic                 res_ready,
  input  aspd_pkg::duty_res_t  res,
  aspd_out_if.source           out_ch
);
  import aspd_pkg::*;

  logic                rv_r;
  logic [REPEAT_W-1:0] cnt_r, cnt_nxt;
  logic [DUTY_W-1:0]   duty_r;
  logic                eob_r;
  logic                last;
  logic                load;

  assign last      = (cnt_r == REPEAT_W'(1));
  // refill on the final copy so back-to-back words leave no gap
  assign res_ready = !rv_r || (out_ch.ready && last);
  assign load      = res_valid && res_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = res.copies;
    end else if (rv_r && out_ch.ready) begin
      cnt_nxt = cnt_r - REPEAT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (load) begin
        rv_r <= 1'b1;
      end else if (rv_r && out_ch.ready && last) begin
        rv_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      duty_r <= res.duty;
      eob_r  <= res.eob;
    end
  end

  assign out_ch.valid      = rv_r;
  assign out_ch.duty_count = duty_r;
  assign out_ch.last_copy  = last;
  assign out_ch.block_done = last && eob_r;

endmodule

### hdl/audio_sample_to_pwm_duty.sv
// Audio sample to PWM duty mapper. Each request on in_ch is a signed Q1.31
// sample with its TDM slot; only the slot held in selected_slot is used,
// others are accepted and vanish. A used sample is scaled by the
// Q8.16 gain, saturated to [-1, 1), mapped around period/2 onto the range
// 268.8 .. 0.95*period ticks in Q20.8, clamped, rounded, and sent on out_ch
// repeat_count times (0 counts as 1, above 64 as 64). The final copy has
// last_copy set and carries end_of_block as block_done. Requests pass
// through a four-stage pipeline (gain multiply, saturate and divide-by-five,
// span multiply, offset/clamp/round) and then the output repeater, which
// emits one word per cycle while out_ch is ready and takes a new word
// only with the last copy of the old one. Without back-pressure the block
// takes one request per cycle if repeat_count is 1 or the slot is not chosen.
// Registers (cfg_ch index): 0 pwm_gain, 1 period_count, 2 repeat_count,
// 3 selected_slot; other indices are ignored. Write only while idle.
module audio_sample_to_pwm_duty (
  input  logic        clk,
  input  logic        rst_n,
  aspd_in_if.sink     in_ch,
  aspd_out_if.source  out_ch,
  aspd_cfg_if.sink    cfg_ch
);
  import aspd_pkg::*;

  cfg_t      cfg;
  duty_res_t res;
  logic      res_valid;
  logic      res_ready;

  // register bank, always ready
  aspd_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // slot filter and the four arithmetic stages
  aspd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // holds one duty word and counts out its copies
  aspd_repeater u_rep (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_ch    (out_ch)
  );

endmodule

### tb/tb_audio_sample_to_pwm_duty.sv
`timescale 1ns / 1ps

module tb_audio_sample_to_pwm_duty;
  import aspd_pkg::*;

  // run control
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 12;   // pipeline depth plus margin
  localparam int HOLD_CYCLES   = 400;  // long receiver back-pressure
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_SAMPLES = 17;   // selected-slot samples per phase

  // index outside the register map: the write must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd9;

  // receiver stall patterns
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_t;

  // one sample request as handed to the driver
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]          chan;
    logic                       eob;
  } sample_req_t;

  // one duty word as the block should emit it
  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              last;
    logic              done;
  } duty_word_t;

  logic clk;
  logic rst_n = 1'b0;

  aspd_in_if  in_ch ();
  aspd_out_if out_ch ();
  aspd_cfg_if cfg_ch ();

  audio_sample_to_pwm_duty u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // local copy of the register file, updated on each accepted write
  logic [GAIN_W-1:0]   gain_r   = GAIN_RST;
  logic [PERIOD_W-1:0] period_r = PERIOD_RST;
  logic [REPEAT_W-1:0] repeat_r = REPEAT_RST;
  logic [CHAN_W-1:0]   slot_r   = SLOT_RST;

  sample_req_t sample_fifo[$];     // waiting to be offered
  duty_word_t  duty_words_q[$];    // predicted output, oldest first
  int samples_queued = 0;
  int samples_taken  = 0;
  int err_cnt        = 0;
  int hold_req       = 0;          // bumped by the sequencer to ask for a hold
  int cycle_cnt      = 0;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // Duty word for one sample under the current register copy. All maths in
  // 64-bit signed; >>> gives the floor of a signed shift.
  function automatic logic [DUTY_W-1:0] duty_for_sample(input logic signed [SAMPLE_W-1:0] smp);
    longint s;
    longint g;
    longint centre;
    longint dmax;
    longint duty;
    logic [63:0] rounded;
    s = longint'(smp);
    g = (s * longint'(gain_r)) >>> 16;
    if (g > 64'sd2147483647)  g = 64'sd2147483647;
    if (g < -64'sd2147483648) g = -64'sd2147483648;
    centre = longint'(period_r >> 1) * 256;
    dmax   = longint'((64'(period_r) * 64'd1216 + 64'd2) / 64'd5);
    duty   = centre + ((g * (dmax - longint'(DUTY_MIN_Q8))) >>> 32);
    // lower clamp first, so a tiny period ends up pinned to dmax
    if (duty < longint'(DUTY_MIN_Q8)) duty = longint'(DUTY_MIN_Q8);
    if (duty > dmax) duty = dmax;
    if (duty < 0) duty = 0;
    rounded = 64'(duty) + 64'd128;
    return rounded[8 +: DUTY_W];
  endfunction

  // Expected words for one accepted request; other slots give nothing.
  task automatic record_expected(input sample_req_t req);
    int copies;
    duty_word_t w;
    if (int'(slot_r) >= SLOT_COUNT || req.chan != slot_r) return;
    copies = int'(repeat_r);
    if (copies == 0) copies = 1;
    if (copies > MAX_REPEAT) copies = MAX_REPEAT;
    w.duty = duty_for_sample(req.sample);
    for (int k = 0; k < copies; k++) begin
      w.last = (k == copies - 1);
      w.done = w.last ? req.eob : 1'b0;
      duty_words_q.push_back(w);
    end
  endtask

  function automatic void mirror_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DAT_W-1:0] dat);
    case (idx)
      REG_PWM_GAIN:      gain_r   = dat[GAIN_W-1:0];
      REG_PERIOD_COUNT:  period_r = dat[PERIOD_W-1:0];
      REG_REPEAT_COUNT:  repeat_r = dat[REPEAT_W-1:0];
      REG_SELECTED_SLOT: slot_r   = dat[CHAN_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------------
  sample_req_t cur_req;
  logic        nxt_valid;
  int          burst_left = 1;
  int          gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      nxt_valid = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        record_expected(cur_req);
        samples_taken++;
        nxt_valid = 1'b0;
      end
      // a request held under back-pressure stays put; otherwise fetch next
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_fifo.size() > 0) begin
          cur_req = sample_fifo.pop_front();
          nxt_valid = 1'b1;
          in_ch.sample        <= cur_req.sample;
          in_ch.channel_index <= cur_req.chan;
          in_ch.end_of_block  <= cur_req.eob;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            // a third of bursts run straight on with no gap
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_ch.valid <= nxt_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern of its own, plus a long hold on request
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode   = RX_OPEN;
  int       mode_left = 0;
  int       hold_left = 0;
  int       hold_seen = 0;
  logic     nxt_ready;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 64);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   nxt_ready = 1'b1;
          RX_COIN:   nxt_ready = 1'($urandom_range(0, 1));
          RX_MOSTLY: nxt_ready = ($urandom_range(0, 3) != 0);
          default:   nxt_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
      out_ch.ready <= nxt_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each accepted word against the oldest prediction
  // ---------------------------------------------------------------------------
  duty_word_t want;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (duty_words_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("unexpected duty word: duty=%0d last=%0b done=%0b",
                   out_ch.duty_count, out_ch.last_copy, out_ch.block_done);
      end else begin
        want = duty_words_q.pop_front();
        if (out_ch.duty_count !== want.duty || out_ch.last_copy !== want.last ||
            out_ch.block_done !== want.done) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("mismatch: exp duty=%0d last=%0b done=%0b, got duty=%0d last=%0b done=%0b",
                     want.duty, want.last, want.done,
                     out_ch.duty_count, out_ch.last_copy, out_ch.block_done);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------------------
  task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic [CHAN_W-1:0] ch,
                             input logic eob);
    sample_req_t r;
    r.sample = smp;
    r.chan   = ch;
    r.eob    = eob;
    sample_fifo.push_back(r);
    samples_queued++;
  endtask

  // everything offered is taken and every word has come out; the settle
  // covers a dropped sample still inside the pipeline
  task automatic wait_idle();
    while (samples_taken != samples_queued || duty_words_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] dat);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= dat;
    do @(posedge clk); while (!cfg_ch.ready);
    mirror_reg(idx, dat);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    logic [SAMPLE_W-1:0] smp;
    case ($urandom_range(0, 9))
      0: smp = 32'h7FFF_FFFF;
      1: smp = 32'h8000_0000;
      2: begin
        // near zero, either sign
        smp = SAMPLE_W'($urandom_range(0, 32'h000F_FFFF));
        if ($urandom_range(0, 1)) smp = -smp;
      end
      default: smp = $urandom;
    endcase
    return smp;
  endfunction

  // Random register set, then a phase of mostly selected-slot samples with
  // some other-slot noise mixed in.
  task automatic run_random_phase(input bit with_hold, input bit with_pause);
    int picked;
    bit paused;
    logic [CHAN_W-1:0]   ch;
    logic [GAIN_W-1:0]   g;
    logic [PERIOD_W-1:0] p;
    logic [REPEAT_W-1:0] r;
    wait_idle();
    case ($urandom_range(0, 5))
      0: g = '0;
      1: g = GAIN_RST;
      2: g = '1;
      3: g = GAIN_W'($urandom_range(0, 24'h01_FFFF));
      default: g = GAIN_W'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: p = PERIOD_W'($urandom_range(0, 511));
      1: p = 20'd512;
      2: p = '1;
      default: p = PERIOD_W'($urandom_range(512, 20'hF_FFFF));
    endcase
    case ($urandom_range(0, 7))
      0: r = '0;
      1: r = 7'(MAX_REPEAT);
      2: r = REPEAT_W'($urandom_range(MAX_REPEAT + 1, 127));
      default: r = REPEAT_W'($urandom_range(1, 8));
    endcase
    // junk in the unused upper data bits must be dropped
    write_reg(REG_PWM_GAIN, g);
    write_reg(REG_PERIOD_COUNT, {4'($urandom), p});
    write_reg(REG_REPEAT_COUNT, {17'($urandom), r});
    write_reg(REG_SELECTED_SLOT, {20'($urandom), 4'($urandom)});
    write_reg(REG_UNMAPPED, 24'($urandom));
    repeat (2) @(posedge clk);
    if (with_hold) hold_req++;
    picked = 0;
    paused = 1'b0;
    while (picked < PHASE_SAMPLES) begin
      ch = ($urandom_range(0, 3) == 0) ? 4'($urandom) : slot_r;
      if (ch == slot_r) picked++;
      push_sample(random_sample(), ch, 1'($urandom));
      if (with_pause && !paused && picked == PHASE_SAMPLES / 2) begin
        // sender stops until the block has fully drained
        paused = 1'b1;
        while (samples_taken != samples_queued || duty_words_q.size() != 0) @(posedge clk);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid         = 1'b0;
    in_ch.sample        = '0;
    in_ch.channel_index = '0;
    in_ch.end_of_block  = 1'b0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset settings: unity gain, period 4096, one copy, slot 0
    push_sample(32'h7FFF_FFFF, 4'd0, 1'b0);   // full scale positive
    push_sample(32'h8000_0000, 4'd0, 1'b1);   // full scale negative
    push_sample(32'h0000_0000, 4'd0, 1'b0);   // centre
    push_sample(32'hFFFF_FFFF, 4'd0, 1'b0);   // one LSB below zero
    push_sample(32'h4000_0000, 4'd5, 1'b1);   // other slot, dropped with its mark
    push_sample(32'hC000_0000, 4'd0, 1'b0);

    // max gain drives both saturation limits; repeat zero means one copy
    wait_idle();
    write_reg(REG_PWM_GAIN, 24'hFF_FFFF);
    write_reg(REG_REPEAT_COUNT, 24'd0);
    write_reg(REG_SELECTED_SLOT, 24'd15);
    repeat (2) @(posedge clk);
    push_sample(32'h0100_0000, 4'd15, 1'b0);
    push_sample(32'hF000_0000, 4'd15, 1'b1);
    push_sample(32'h1234_5678, 4'd0, 1'b0);   // old slot no longer chosen
    push_sample(32'h0000_0001, 4'd15, 1'b0);

    // period too short for the span: clamp to dmax wins; repeat past max
    wait_idle();
    write_reg(REG_PERIOD_COUNT, 24'd100);
    write_reg(REG_REPEAT_COUNT, 24'd127);
    write_reg(REG_PWM_GAIN, 24'd0);
    repeat (2) @(posedge clk);
    push_sample(32'h7FFF_FFFF, 4'd15, 1'b1);

    // zero period gives zero duty
    wait_idle();
    write_reg(REG_PERIOD_COUNT, 24'd0);
    write_reg(REG_REPEAT_COUNT, 24'd3);
    repeat (2) @(posedge clk);
    push_sample(32'h8000_0000, 4'd15, 1'b0);
    push_sample(32'h5555_5555, 4'd15, 1'b1);

    // widest period, full repeat; a write off the map must change nothing
    wait_idle();
    write_reg(REG_PERIOD_COUNT, 24'h0F_FFFF);
    write_reg(REG_REPEAT_COUNT, 24'(MAX_REPEAT));
    write_reg(REG_PWM_GAIN, 24'(GAIN_RST));
    write_reg(REG_SELECTED_SLOT, 24'd7);
    write_reg(REG_UNMAPPED, 24'hFF_FFFF);
    repeat (2) @(posedge clk);
    push_sample(32'h7FFF_FFFF, 4'd7, 1'b1);
    push_sample(32'h8000_0000, 4'd7, 1'b0);
    push_sample(32'h0000_0000, 4'd3, 1'b0);

    // shortest legal period, half gain
    wait_idle();
    write_reg(REG_PERIOD_COUNT, 24'd512);
    write_reg(REG_REPEAT_COUNT, 24'd2);
    write_reg(REG_PWM_GAIN, 24'h00_8000);
    repeat (2) @(posedge clk);
    push_sample(32'h7FFF_FFFF, 4'd7, 1'b0);
    push_sample(32'h8000_0001, 4'd7, 1'b1);
    push_sample($urandom, 4'd7, 1'b0);

    // random phases: the first under a long hold, the third with a drain
    for (int ph = 0; ph < RANDOM_PHASES; ph++)
      run_random_phase(ph == 0, ph == 2);

    wait_idle();
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
hdl/aspd_pkg.sv
hdl/aspd_in_if.sv
hdl/aspd_out_if.sv
hdl/aspd_cfg_if.sv
hdl/aspd_cfg_regs.sv
hdl/aspd_datapath.sv
hdl/aspd_repeater.sv
hdl/audio_sample_to_pwm_duty.sv
tb/tb_audio_sample_to_pwm_duty.sv
